// ===== hw/rtl/pdsm_pkg.sv =====
// ----------------------------------------------------------------------------
// pdsm_pkg
// shared types and constants for the position drive stuck monitor
// ----------------------------------------------------------------------------
package pdsm_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;
   localparam int BAND_W      = 10;
   localparam int COUNT_W     = 8;
   localparam int FAULT_W     = 2;
   localparam int RSP_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_BACKLASH_BAND   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTION_DEADBAND = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STUCK_TICKS     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_TICKS    = 2'd3;

   localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_STUCK_FWD = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_STUCK_BWD = 2'd2;
   localparam logic [FAULT_W-1:0] FAULT_NO_MOTION = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [BAND_W-1:0]  backlash_band;
      logic [BAND_W-1:0]  motion_deadband;
      logic [COUNT_W-1:0] stuck_ticks;
      logic [COUNT_W-1:0] settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic               prev_dir;
      logic [COUNT_W-1:0] reverse_count;
      logic [COUNT_W-1:0] still_count;
      logic [COUNT_W-1:0] settle_count;
      logic               reached;
      logic [FAULT_W-1:0] fault;
      logic               running;
   } state_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
   endfunction

endpackage

// ===== hw/rtl/position_drive_stuck_monitor.sv =====
// ----------------------------------------------------------------------------
// position_drive_stuck_monitor
// drive direction, stop and stuck-fault monitor for one positioning axis
// rsp path: the req transfer is captured in the input reg, then the result reg drives rsp valid
// throughput: one tick per cycle while the rsp side is not stalled, set by the combinational step logic
// a stalled rsp side holds the result reg and then the input reg
// reset: synchronous, clears state, counters and fault; control registers take defaults
// ----------------------------------------------------------------------------
module position_drive_stuck_monitor import pdsm_pkg::*; #(
   parameter int POS_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // actual_pos, goal_pos, smoothed_pos, limit_low, limit_high, zero pad
   input  logic [((3*POS_BITS+2+7)/8)*8-1:0]      req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // drive_dir, drive_on, reached_flag, fault_code[1:0], zero pad
   output logic [RSP_DATA_W-1:0]                  rsp_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [CSR_INDEX_W-1:0]                 csr_index,
   input  logic [CSR_DATA_W-1:0]                  csr_data
);

   logic                       in_valid_ff;
   logic signed [POS_BITS-1:0] in_pos_ff;
   logic signed [POS_BITS-1:0] in_goal_ff;
   logic signed [POS_BITS-1:0] in_smooth_ff;
   logic                       in_lo_ff;
   logic                       in_hi_ff;
   cfg_type                    cfg_ff;
   state_type                  st_ff;
   state_type                  st_in;
   logic signed [POS_BITS-1:0] prev_smoothed_ff;
   logic                       rsp_valid_ff;
   logic [RSP_DATA_W-1:0]      rsp_data_ff;
   logic [RSP_DATA_W-1:0]      rsp_data_in;
   logic                       step_go;
   logic                       update_prev;
   logic                       dir;

   assign step_go    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_go;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pdsm_step #(
      .POS_BITS(POS_BITS)
   ) u_step (
      .cfg          (cfg_ff),
      .st_cur       (st_ff),
      .prev_smoothed(prev_smoothed_ff),
      .actual_pos   (in_pos_ff),
      .goal_pos     (in_goal_ff),
      .smoothed_pos (in_smooth_ff),
      .limit_low    (in_lo_ff),
      .limit_high   (in_hi_ff),
      .st_nxt       (st_in),
      .update_prev  (update_prev),
      .drive_dir    (dir)
   );

   assign rsp_data_in = RSP_DATA_W'({st_in.fault, st_in.reached, st_in.running, dir});

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_pos_ff    <= req_tdata[POS_BITS-1:0];
         in_goal_ff   <= req_tdata[2*POS_BITS-1:POS_BITS];
         in_smooth_ff <= req_tdata[3*POS_BITS-1:2*POS_BITS];
         in_lo_ff     <= req_tdata[3*POS_BITS];
         in_hi_ff     <= req_tdata[3*POS_BITS+1];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.backlash_band   <= BAND_W'(2);
         cfg_ff.motion_deadband <= BAND_W'(1);
         cfg_ff.stuck_ticks     <= COUNT_W'(10);
         cfg_ff.settle_ticks    <= COUNT_W'(5);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BACKLASH_BAND:   cfg_ff.backlash_band   <= csr_data;
            CSR_MOTION_DEADBAND: cfg_ff.motion_deadband <= csr_data;
            CSR_STUCK_TICKS:     cfg_ff.stuck_ticks     <= csr_data[COUNT_W-1:0];
            CSR_SETTLE_TICKS:    cfg_ff.settle_ticks    <= csr_data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // tick state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff            <= '0;
         prev_smoothed_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (step_go) begin
            st_ff <= st_in;
            if (update_prev) begin
               prev_smoothed_ff <= in_smooth_ff;
            end
         end
         if (step_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (step_go) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== hw/rtl/pdsm_step.sv =====
// ----------------------------------------------------------------------------
// pdsm_step
// one control tick: direction, stop checks, drive enable and fault detection
// ----------------------------------------------------------------------------
module pdsm_step import pdsm_pkg::*; #(
   parameter int POS_BITS = 16
) (
   input  cfg_type                    cfg,
   input  state_type                  st_cur,
   input  logic signed [POS_BITS-1:0] prev_smoothed,
   input  logic signed [POS_BITS-1:0] actual_pos,
   input  logic signed [POS_BITS-1:0] goal_pos,
   input  logic signed [POS_BITS-1:0] smoothed_pos,
   input  logic                       limit_low,
   input  logic                       limit_high,
   output state_type                  st_nxt,
   output logic                       update_prev,
   output logic                       drive_dir
);

   localparam int CW = POS_BITS + 12;

   logic signed [CW-1:0] pos_x;
   logic signed [CW-1:0] tgt_x;
   logic signed [CW-1:0] band_x;
   logic signed [CW-1:0] dz_x;
   logic signed [CW-1:0] delta_x;
   logic                 far_low;
   logic                 far_high;
   logic                 moving_dn;
   logic                 moving_up;
   logic                 no_motion;
   logic [COUNT_W-1:0]   settle_base;

   assign pos_x     = CW'(actual_pos);
   assign tgt_x     = CW'(goal_pos);
   assign band_x    = CW'($signed({1'b0, cfg.backlash_band}));
   assign dz_x      = CW'($signed({1'b0, cfg.motion_deadband}));
   assign delta_x   = CW'(smoothed_pos) - CW'(prev_smoothed);
   assign far_low   = (pos_x + band_x) < tgt_x;
   assign far_high  = pos_x > (tgt_x + band_x);
   assign moving_dn = delta_x < -dz_x;
   assign moving_up = delta_x > dz_x;
   assign no_motion = (delta_x == '0) || ((delta_x > -dz_x) && (delta_x < dz_x));
   assign drive_dir = actual_pos < goal_pos;
   assign settle_base = (drive_dir != st_cur.prev_dir) ? '0 : st_cur.settle_count;

   always_comb begin
      st_nxt              = st_cur;
      st_nxt.prev_dir     = drive_dir;
      st_nxt.settle_count = settle_base;
      update_prev         = 1'b0;
      if ((drive_dir && limit_high) || (!drive_dir && limit_low)) begin
         st_nxt.running = 1'b0;
         st_nxt.reached = 1'b1;
      end else if (actual_pos == goal_pos) begin
         st_nxt.running       = 1'b0;
         st_nxt.reached       = 1'b1;
         st_nxt.fault         = FAULT_NONE;
         st_nxt.reverse_count = '0;
         st_nxt.still_count   = '0;
         st_nxt.settle_count  = '0;
      end else begin
         update_prev = 1'b1;
         if (far_low || far_high || !st_cur.reached) begin
            st_nxt.running = 1'b1;
            st_nxt.reached = 1'b0;
         end
         // wrong-way motion check
         if (far_low) begin
            if (moving_dn) begin
               st_nxt.reverse_count = sat_inc(st_cur.reverse_count);
               if (sat_inc(st_cur.reverse_count) >= cfg.stuck_ticks) begin
                  st_nxt.fault   = FAULT_STUCK_FWD;
                  st_nxt.running = 1'b0;
               end
            end else if (moving_up) begin
               st_nxt.reverse_count = '0;
            end
         end else if (far_high) begin
            if (moving_up) begin
               st_nxt.reverse_count = sat_inc(st_cur.reverse_count);
               if (sat_inc(st_cur.reverse_count) >= cfg.stuck_ticks) begin
                  st_nxt.fault   = FAULT_STUCK_BWD;
                  st_nxt.running = 1'b0;
               end
            end else if (moving_dn) begin
               st_nxt.reverse_count = '0;
            end
         end
         // no-motion check after settling
         if (settle_base < cfg.settle_ticks) begin
            st_nxt.settle_count = settle_base + COUNT_W'(1);
         end else if (no_motion && !st_nxt.reached) begin
            st_nxt.still_count = sat_inc(st_cur.still_count);
            if (sat_inc(st_cur.still_count) >= cfg.stuck_ticks) begin
               st_nxt.fault   = FAULT_NO_MOTION;
               st_nxt.running = 1'b0;
            end
         end else begin
            st_nxt.still_count = '0;
         end
      end
   end

endmodule

// ===== hw/rtl/pdsm_checker.sv =====
// ----------------------------------------------------------------------------
// pdsm_checker
// port-level checks on the result channel of the stuck monitor
// ----------------------------------------------------------------------------
module pdsm_checker import pdsm_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // drive never runs with target reached
   a_run_reached: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && rsp_tdata[2]))
      else $error("drive on while reached");

   // pad bits stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:5] == '0))
      else $error("result pad bits set");

endmodule

bind position_drive_stuck_monitor pdsm_checker u_pdsm_checker (.*);
